/* src/z85_pkg.sv */
// ============================================================================
// z85_pkg
// Shared constants, types and helper functions for the rotating Z85 encoder.
// ============================================================================
package z85_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned DIGIT_W       = 7;
    localparam int unsigned DIGITS        = 5;
    localparam int unsigned FRONT_STAGES  = 4;
    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned TDATA_W       = ((DIGITS * DIGIT_W + 7) / 8) * 8;
    localparam int unsigned RECIP_SHIFT   = 38;

    localparam logic [WORD_W-1:0]  BASE_WORD  = 32'd85;
    localparam logic [WORD_W-1:0]  RECIP_85   = 32'hC0C0C0C1;
    localparam logic [DIGIT_W:0]   BASE_WIDE  = 8'd85;
    localparam logic [DIGIT_W-1:0] BASE       = 7'd85;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 7'd84;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [DIGIT_W-1:0] ALPHABET [85] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
        7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A,
        7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74,
        7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A, 7'h41, 7'h42, 7'h43, 7'h44,
        7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E,
        7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
        7'h59, 7'h5A, 7'h2E, 7'h2D, 7'h3A, 7'h2B, 7'h3D, 7'h5E, 7'h21, 7'h2F,
        7'h2A, 7'h3F, 7'h26, 7'h3C, 7'h3E, 7'h28, 7'h29, 7'h5B, 7'h5D, 7'h7B,
        7'h7D, 7'h40, 7'h25, 7'h24, 7'h23
    };

    // quotient by 85, exact for every 32-bit value
    function automatic logic [WORD_W-1:0] div85(input logic [WORD_W-1:0] v);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(v) * (2*WORD_W)'(RECIP_85);
        return {{RECIP_SHIFT-WORD_W{1'b0}}, prod[2*WORD_W-1:RECIP_SHIFT]};
    endfunction

    function automatic digit_t mod85_add(input digit_t a, input digit_t b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, MAX_DIGIT})
        begin
            s = s - BASE_WIDE;
        end
        return s[DIGIT_W-1:0];
    endfunction

    function automatic digit_t mod85_sub(input digit_t d, input digit_t r);
        logic [DIGIT_W:0] s;
        if (d >= r)
        begin
            s = {1'b0, d} - {1'b0, r};
        end
        else
        begin
            s = {1'b0, d} + BASE_WIDE - {1'b0, r};
        end
        return s[DIGIT_W-1:0];
    endfunction

    function automatic digit_t z85_char(input digit_t idx);
        digit_t i;
        i = (idx > MAX_DIGIT) ? MAX_DIGIT : idx;
        return ALPHABET[i];
    endfunction

endpackage

/* src/z85_front.sv */
// ============================================================================
// z85_front
// Input stage: splits each word into five base-85 digits over four stages.
// ============================================================================
module z85_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [z85_pkg::WORD_W-1:0]           s_tdata,   // data_word
    input  z85_pkg::q_status_t                   q_status,
    output logic                                 q_push,
    output z85_pkg::digit_vec_t                  q_push_data
);
    import z85_pkg::*;

    logic [FRONT_STAGES-1:0]  valid_reg;
    logic [FRONT_STAGES-1:0]  valid_next;
    logic [WORD_W-1:0]        word_reg [FRONT_STAGES];
    logic [WORD_W-1:0]        word_next [FRONT_STAGES];
    logic [WORD_W-1:0]        quo_reg [FRONT_STAGES];
    logic [WORD_W-1:0]        quo_next [FRONT_STAGES];
    digit_vec_t               dig_reg [FRONT_STAGES];
    digit_vec_t               dig_next [FRONT_STAGES];
    logic                     advance;
    logic [WORD_W-1:0]        rem_last;

    assign advance  = !(valid_reg[FRONT_STAGES-1] && q_status.full);
    assign s_tready = advance;
    assign q_push   = valid_reg[FRONT_STAGES-1] && !q_status.full;

    always_comb
    begin
        logic [WORD_W-1:0] rem;
        valid_next = {valid_reg[FRONT_STAGES-2:0], s_tvalid};
        word_next[0] = s_tdata;
        quo_next[0]  = div85(s_tdata);
        dig_next[0]  = '0;
        for (int k = 1; k < FRONT_STAGES; k++)
        begin
            rem = word_reg[k-1] - quo_reg[k-1] * BASE_WORD;
            word_next[k] = quo_reg[k-1];
            quo_next[k]  = div85(quo_reg[k-1]);
            dig_next[k]  = dig_reg[k-1];
            dig_next[k][DIGITS-k] = rem[DIGIT_W-1:0];
        end
    end

    assign rem_last = word_reg[FRONT_STAGES-1] - quo_reg[FRONT_STAGES-1] * BASE_WORD;

    always_comb
    begin
        q_push_data    = dig_reg[FRONT_STAGES-1];
        q_push_data[1] = rem_last[DIGIT_W-1:0];
        q_push_data[0] = quo_reg[FRONT_STAGES-1][DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < FRONT_STAGES; k++)
            begin
                word_reg[k] <= word_next[k];
                quo_reg[k]  <= quo_next[k];
                dig_reg[k]  <= dig_next[k];
            end
        end
    end

endmodule

/* src/z85_fifo.sv */
// ============================================================================
// z85_fifo
// Short digit queue between the splitting front and the encoding back.
// ============================================================================
module z85_fifo #(
    parameter int unsigned DEPTH = z85_pkg::FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  z85_pkg::digit_vec_t  push_data,
    input  logic                 pop,
    output z85_pkg::digit_vec_t  pop_data,
    output z85_pkg::q_status_t   status
);
    import z85_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    digit_vec_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/z85_back.sv */
// ============================================================================
// z85_back
// Output stage: rotates each digit, maps it to the alphabet, holds the word.
// ============================================================================
module z85_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [z85_pkg::DIGIT_W-1:0]       cfg_data,
    input  z85_pkg::q_status_t                q_status,
    input  z85_pkg::digit_vec_t               q_pop_data,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [z85_pkg::TDATA_W-1:0]       m_tdata
);
    import z85_pkg::*;

    localparam int unsigned PAD_W = TDATA_W - DIGITS * DIGIT_W;

    digit_t      step_mod_reg;
    digit_t      step_mod_next;
    digit_t      mult_reg [DIGITS];
    digit_t      mult_next [DIGITS];
    digit_t      offset_reg;
    digit_t      offset_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    digit_vec_t  chars_reg;
    digit_vec_t  chars_next;

    assign cfg_ready = 1'b1;
    assign q_pop     = !q_status.empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, chars_reg};

    always_comb
    begin
        step_mod_next = step_mod_reg;
        if (cfg_valid)
        begin
            step_mod_next = (cfg_data > MAX_DIGIT) ? cfg_data - BASE : cfg_data;
        end
        mult_next[0] = step_mod_reg;
        for (int k = 1; k < DIGITS; k++)
        begin
            mult_next[k] = mod85_add(mult_reg[k-1], step_mod_reg);
        end
    end

    always_comb
    begin
        digit_t rot;
        chars_next[0] = z85_char(mod85_sub(q_pop_data[0], offset_reg));
        for (int k = 1; k < DIGITS; k++)
        begin
            rot = mod85_add(offset_reg, mult_reg[k-1]);
            chars_next[k] = z85_char(mod85_sub(q_pop_data[k], rot));
        end
        offset_next   = q_pop ? mod85_add(offset_reg, mult_reg[DIGITS-1]) : offset_reg;
        m_tvalid_next = q_pop || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mod_reg <= '0;
            offset_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < DIGITS; k++)
            begin
                mult_reg[k] <= '0;
            end
        end
        else
        begin
            step_mod_reg <= step_mod_next;
            offset_reg   <= offset_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int k = 0; k < DIGITS; k++)
            begin
                mult_reg[k] <= mult_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            chars_reg <= chars_next;
        end
    end

endmodule

/* src/z85_rotating_encoder_core.sv */
// ============================================================================
// z85_rotating_encoder_core
// Rotating Z85 encoder: one 32-bit word in, five rotated characters out.
// ============================================================================
// Slave stream s_*: one data_word per handshake in s_tdata.
// Master stream m_*: one word of five 7-bit characters, char_0 in the lowest
// bits, the most significant base-85 digit first.
// Config channel cfg_*: writes rotation_step; always ready. Write only while
// the encoder is drained, at least two cycles before the next input word.
// Path from s_* handshake to m_tvalid: the four-stage digit splitter (one
// reciprocal multiply per stage), the queue write and the output register.
// Throughput: one word per cycle sustained while m_tready stays high.
// Stall: the output register holds its word while m_tready is low; the digit
// queue (FIFO_DEPTH words) keeps filling, then the splitter stops and
// s_tready drops.
// Reset: rotation offset and step clear to zero, queue and pipelines empty.
// ============================================================================
module z85_rotating_encoder_core #(
    parameter int unsigned FIFO_DEPTH = z85_pkg::FIFO_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [z85_pkg::WORD_W-1:0]      s_tdata,    // data_word
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [z85_pkg::TDATA_W-1:0]     m_tdata,    // char_0..char_4, zero pad
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [z85_pkg::DIGIT_W-1:0]     cfg_data    // rotation_step
);
    import z85_pkg::*;

    q_status_t   q_status;
    logic        q_push;
    logic        q_pop;
    digit_vec_t  q_push_data;
    digit_vec_t  q_pop_data;

    z85_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    z85_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    z85_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .q_pop_data (q_pop_data),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    // drop no word at the queue input
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("push into full digit queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_status.empty))
        else $error("pop from empty digit queue");

    a_chars_printable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] >= 7'd33 && m_tdata[6:0] <= 7'd125
                   && m_tdata[13:7] >= 7'd33 && m_tdata[13:7] <= 7'd125
                   && m_tdata[20:14] >= 7'd33 && m_tdata[20:14] <= 7'd125
                   && m_tdata[27:21] >= 7'd33 && m_tdata[27:21] <= 7'd125
                   && m_tdata[34:28] >= 7'd33 && m_tdata[34:28] <= 7'd125))
        else $error("output character outside alphabet range");
`endif

endmodule
